/* src/sbcp_pkg.sv */
`timescale 1ns / 1ps

package sbcp_pkg;

   localparam int NAME_BYTES_DEF = 20;
   localparam int NAME_IDX_W = 5;
   localparam int JOBQ_DEPTH = 2;
   localparam int CSR_IDX_W = 2;

   // Action codes on the result channel.
   localparam logic [2:0] ACT_SEND    = 3'd0;
   localparam logic [2:0] ACT_LATCH   = 3'd1;
   localparam logic [2:0] ACT_COMMIT  = 3'd2;
   localparam logic [2:0] ACT_ERASE   = 3'd3;
   localparam logic [2:0] ACT_RUN     = 3'd4;
   localparam logic [2:0] ACT_RESTART = 3'd5;

   // Job kinds handed from the parser to the sequencer.
   localparam logic [2:0] JOB_ACK     = 3'd0;
   localparam logic [2:0] JOB_INFO    = 3'd1;
   localparam logic [2:0] JOB_RUN     = 3'd2;
   localparam logic [2:0] JOB_RESTART = 3'd3;
   localparam logic [2:0] JOB_ERASE   = 3'd4;
   localparam logic [2:0] JOB_COMMIT  = 3'd5;
   localparam logic [2:0] JOB_LATCH   = 3'd6;

   localparam logic [7:0] CH_START = 8'h5B;
   localparam logic [7:0] CH_SYNC  = 8'h53;
   localparam logic [7:0] CH_INFO  = 8'h49;
   localparam logic [7:0] CH_BOOT  = 8'h42;
   localparam logic [7:0] CH_RUN   = 8'h52;
   localparam logic [7:0] CH_WRITE = 8'h57;
   localparam logic [7:0] CH_ERASE = 8'h45;

   localparam logic [15:0] INFO_VERSION = 16'h0100;

   localparam logic [CSR_IDX_W-1:0] CSR_FLASH_SIZE = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_ROW_SIZE   = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_LOADER     = 2'd2;

   localparam logic [15:0] FLASH_SIZE_RST = 16'd4096;
   localparam logic [15:0] ROW_SIZE_RST   = 16'd32;
   localparam logic [15:0] LOADER_RST     = 16'd3584;

   typedef struct packed {
      logic [2:0]  kind;
      logic [7:0]  cmd;
      logic [15:0] addr;
      logic [15:0] word;
   } job_type;

   // Zero-padded device name text.
   function automatic logic [7:0] name_byte(input logic [NAME_IDX_W-1:0] idx);
      logic [7:0] b;
      unique case (idx)
         5'd0:    b = 8'h42;
         5'd1:    b = 8'h75;
         5'd2:    b = 8'h63;
         5'd3:    b = 8'h6B;
         5'd4:    b = 8'h43;
         5'd5:    b = 8'h6C;
         5'd6:    b = 8'h69;
         5'd7:    b = 8'h63;
         5'd8:    b = 8'h6B;
         default: b = 8'h00;
      endcase
      return b;
   endfunction

endpackage

/* src/sbcp_front.sv */
`timescale 1ns / 1ps

module sbcp_front import sbcp_pkg::*; (
   input  logic       clock,
   input  logic       reset,
   input  logic       byte_valid,
   input  logic [7:0] rx_byte,
   output logic       job_push,
   output job_type    job
);

   localparam logic [2:0] PH_HUNT  = 3'd0;
   localparam logic [2:0] PH_CMD   = 3'd1;
   localparam logic [2:0] PH_ADDR  = 3'd2;
   localparam logic [2:0] PH_COUNT = 3'd3;
   localparam logic [2:0] PH_DATA  = 3'd4;

   logic [2:0]  phase_ff, phase_in;
   logic        is_erase_ff, is_erase_in;
   logic [1:0]  fbs_ff, fbs_in;
   logic [15:0] addr_ff, addr_in;
   logic [15:0] words_ff, words_in;
   logic [7:0]  hold_ff, hold_in;
   logic [15:0] first_ff, first_in;
   logic        is_first_ff, is_first_in;
   logic [15:0] word_rx;

   assign word_rx = {rx_byte, hold_ff};

   always_comb begin
      phase_in    = phase_ff;
      is_erase_in = is_erase_ff;
      fbs_in      = fbs_ff;
      addr_in     = addr_ff;
      words_in    = words_ff;
      hold_in     = hold_ff;
      first_in    = first_ff;
      is_first_in = is_first_ff;
      job_push    = 1'b0;
      job.kind    = JOB_RESTART;
      job.cmd     = rx_byte;
      job.addr    = addr_ff;
      job.word    = first_ff;
      if (byte_valid) begin
         unique case (phase_ff)
            PH_CMD: begin
               phase_in    = PH_HUNT;
               is_erase_in = (rx_byte == CH_ERASE);
               job_push    = 1'b1;
               if (rx_byte == CH_SYNC || rx_byte == CH_BOOT) begin
                  job.kind = JOB_ACK;
               end else if (rx_byte == CH_INFO) begin
                  job.kind = JOB_INFO;
               end else if (rx_byte == CH_RUN) begin
                  job.kind = JOB_RUN;
               end else if (rx_byte == CH_ERASE || rx_byte == CH_WRITE) begin
                  job_push = 1'b0;
                  phase_in = PH_ADDR;
                  fbs_in   = 2'd0;
               end else begin
                  job.kind = JOB_RESTART;
               end
            end
            PH_ADDR: begin
               if (fbs_ff == 2'd0) begin
                  addr_in = {8'h00, rx_byte};
               end else if (fbs_ff == 2'd1) begin
                  addr_in = {rx_byte, addr_ff[7:0]};
               end
               fbs_in = fbs_ff + 2'd1;
               // The two bytes after the address are skipped.
               if (fbs_ff == 2'd3) begin
                  if (is_erase_ff) begin
                     job_push = 1'b1;
                     job.kind = JOB_ERASE;
                     phase_in = PH_HUNT;
                  end else begin
                     phase_in = PH_COUNT;
                  end
               end
            end
            PH_COUNT: begin
               if (fbs_ff == 2'd0) begin
                  hold_in = rx_byte;
                  fbs_in  = 2'd1;
               end else begin
                  fbs_in   = 2'd0;
                  words_in = word_rx;
                  if (word_rx == 16'd0) begin
                     // An empty write commits the first word of the last write that had any words.
                     job_push = 1'b1;
                     job.kind = JOB_COMMIT;
                     phase_in = PH_HUNT;
                  end else begin
                     is_first_in = 1'b1;
                     phase_in    = PH_DATA;
                  end
               end
            end
            PH_DATA: begin
               if (fbs_ff == 2'd0) begin
                  hold_in = rx_byte;
                  fbs_in  = 2'd1;
               end else begin
                  fbs_in   = 2'd0;
                  job_push = 1'b1;
                  job.word = word_rx;
                  if (is_first_ff) begin
                     first_in    = word_rx;
                     is_first_in = 1'b0;
                  end
                  if (words_ff > 16'd1) begin
                     job.kind = JOB_LATCH;
                     addr_in  = addr_ff + 16'd1;
                     words_in = words_ff - 16'd1;
                  end else begin
                     job.kind = JOB_COMMIT;
                     words_in = 16'd0;
                     phase_in = PH_HUNT;
                  end
               end
            end
            default: begin
               phase_in = (rx_byte == CH_START) ? PH_CMD : PH_HUNT;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff    <= PH_HUNT;
         is_erase_ff <= 1'b0;
         fbs_ff      <= 2'd0;
         addr_ff     <= 16'd0;
         words_ff    <= 16'd0;
         hold_ff     <= 8'd0;
         first_ff    <= 16'd0;
         is_first_ff <= 1'b1;
      end else begin
         phase_ff    <= phase_in;
         is_erase_ff <= is_erase_in;
         fbs_ff      <= fbs_in;
         addr_ff     <= addr_in;
         words_ff    <= words_in;
         hold_ff     <= hold_in;
         first_ff    <= first_in;
         is_first_ff <= is_first_in;
      end
   end

endmodule

/* src/sbcp_jobq.sv */
`timescale 1ns / 1ps

module sbcp_jobq import sbcp_pkg::*; (
   input  logic    clock,
   input  logic    reset,
   input  logic    push,
   input  job_type push_job,
   output logic    full,
   input  logic    pop,
   output logic    head_valid,
   output job_type head_job
);

   localparam int PTR_W = (JOBQ_DEPTH > 1) ? $clog2(JOBQ_DEPTH) : 1;
   localparam int CNT_W = $clog2(JOBQ_DEPTH + 1);
   localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(JOBQ_DEPTH - 1);

   job_type           slot_ff [JOBQ_DEPTH];
   logic [PTR_W-1:0]  wr_ff, wr_in;
   logic [PTR_W-1:0]  rd_ff, rd_in;
   logic [CNT_W-1:0]  cnt_ff, cnt_in;
   logic              do_push, do_pop;

   assign full       = (cnt_ff == CNT_W'(JOBQ_DEPTH));
   assign head_valid = (cnt_ff != '0);
   assign head_job   = slot_ff[rd_ff];
   assign do_push    = push && !full;
   assign do_pop     = pop && head_valid;

   always_comb begin
      wr_in  = wr_ff;
      rd_in  = rd_ff;
      cnt_in = cnt_ff;
      if (do_push) begin
         wr_in = (wr_ff == PTR_LAST) ? '0 : wr_ff + PTR_W'(1);
      end
      if (do_pop) begin
         rd_in = (rd_ff == PTR_LAST) ? '0 : rd_ff + PTR_W'(1);
      end
      if (do_push && !do_pop) begin
         cnt_in = cnt_ff + CNT_W'(1);
      end else if (do_pop && !do_push) begin
         cnt_in = cnt_ff - CNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ff  <= '0;
         rd_ff  <= '0;
         cnt_ff <= '0;
      end else begin
         wr_ff  <= wr_in;
         rd_ff  <= rd_in;
         cnt_ff <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         slot_ff[wr_ff] <= push_job;
      end
   end

endmodule

/* src/sbcp_back.sv */
`timescale 1ns / 1ps

module sbcp_back import sbcp_pkg::*; #(
   parameter int NAME_BYTES = NAME_BYTES_DEF
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 csr_we,
   input  logic [CSR_IDX_W-1:0] csr_index,
   input  logic [15:0]          csr_data,
   input  logic                 job_valid,
   input  job_type              job,
   output logic                 job_pop,
   input  logic                 rsp_pop,
   output logic                 rsp_empty,
   output logic [2:0]           rsp_action,
   output logic [7:0]           rsp_tx_byte,
   output logic [15:0]          rsp_flash_addr,
   output logic [15:0]          rsp_flash_word,
   output logic                 rsp_last
);

   localparam int INFO_LEN = 24 + NAME_BYTES;
   localparam int STEP_W = $clog2(INFO_LEN);
   localparam logic [7:0] INFO_HDR = 8'(23 + NAME_BYTES);

   logic [15:0] flash_words_ff, row_size_ff, loader_ff;
   logic [STEP_W-1:0] step_ff, step_in;
   logic        out_valid_ff, out_valid_in;
   logic [2:0]  act_ff, act_c;
   logic [7:0]  tx_ff, tx_c;
   logic [15:0] addr_ff, addr_c;
   logic [15:0] word_ff, word_c;
   logic        last_ff, final_c;
   logic [7:0]  info_c;
   logic        adv;

   always_ff @(posedge clock) begin
      if (reset) begin
         flash_words_ff <= FLASH_SIZE_RST;
         row_size_ff    <= ROW_SIZE_RST;
         loader_ff      <= LOADER_RST;
      end else if (csr_we) begin
         unique case (csr_index)
            CSR_FLASH_SIZE: flash_words_ff <= csr_data;
            CSR_ROW_SIZE:   row_size_ff    <= csr_data;
            CSR_LOADER:     loader_ff      <= csr_data;
            default: ;
         endcase
      end
   end

   always_comb begin
      unique case (step_ff)
         STEP_W'(0):  info_c = INFO_HDR;
         STEP_W'(1):  info_c = 8'd1;
         STEP_W'(2):  info_c = 8'd1;
         STEP_W'(3):  info_c = 8'd0;
         STEP_W'(4):  info_c = 8'd8;
         STEP_W'(5):  info_c = flash_words_ff[7:0];
         STEP_W'(6):  info_c = flash_words_ff[15:8];
         STEP_W'(7):  info_c = 8'd0;
         STEP_W'(8):  info_c = 8'd0;
         STEP_W'(9):  info_c = 8'd3;
         STEP_W'(10): info_c = row_size_ff[7:0];
         STEP_W'(11): info_c = row_size_ff[15:8];
         STEP_W'(12): info_c = 8'd4;
         STEP_W'(13): info_c = row_size_ff[7:0];
         STEP_W'(14): info_c = row_size_ff[15:8];
         STEP_W'(15): info_c = 8'd5;
         STEP_W'(16): info_c = INFO_VERSION[7:0];
         STEP_W'(17): info_c = INFO_VERSION[15:8];
         STEP_W'(18): info_c = 8'd6;
         STEP_W'(19): info_c = loader_ff[7:0];
         STEP_W'(20): info_c = loader_ff[15:8];
         STEP_W'(21): info_c = 8'd0;
         STEP_W'(22): info_c = 8'd0;
         STEP_W'(23): info_c = 8'd7;
         default:     info_c = name_byte(NAME_IDX_W'(step_ff - STEP_W'(24)));
      endcase
   end

   always_comb begin
      act_c   = ACT_SEND;
      tx_c    = 8'd0;
      addr_c  = 16'd0;
      word_c  = 16'd0;
      final_c = 1'b1;
      unique case (job.kind)
         JOB_ACK: begin
            tx_c    = (step_ff == '0) ? CH_START : job.cmd;
            final_c = (step_ff == STEP_W'(1));
         end
         JOB_INFO: begin
            tx_c    = info_c;
            final_c = (step_ff == STEP_W'(INFO_LEN - 1));
         end
         JOB_RUN: begin
            act_c = ACT_RUN;
         end
         JOB_RESTART: begin
            act_c = ACT_RESTART;
         end
         JOB_ERASE, JOB_COMMIT: begin
            // The flash action comes first, then the two-byte acknowledge.
            final_c = (step_ff == STEP_W'(2));
            if (step_ff == '0) begin
               act_c  = (job.kind == JOB_ERASE) ? ACT_ERASE : ACT_COMMIT;
               addr_c = job.addr;
               word_c = (job.kind == JOB_ERASE) ? 16'd0 : job.word;
            end else if (step_ff == STEP_W'(1)) begin
               tx_c = CH_START;
            end else begin
               tx_c = (job.kind == JOB_ERASE) ? CH_ERASE : CH_WRITE;
            end
         end
         JOB_LATCH: begin
            act_c  = ACT_LATCH;
            addr_c = job.addr;
            word_c = job.word;
         end
         default: ;
      endcase
   end

   assign adv     = job_valid && (!out_valid_ff || rsp_pop);
   assign job_pop = adv && final_c;

   always_comb begin
      step_in      = step_ff;
      out_valid_in = out_valid_ff;
      if (adv) begin
         out_valid_in = 1'b1;
         step_in      = final_c ? '0 : step_ff + STEP_W'(1);
      end else if (rsp_pop) begin
         out_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         step_ff      <= '0;
         out_valid_ff <= 1'b0;
      end else begin
         step_ff      <= step_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         act_ff  <= act_c;
         tx_ff   <= tx_c;
         addr_ff <= addr_c;
         word_ff <= word_c;
         last_ff <= final_c;
      end
   end

   assign rsp_empty      = !out_valid_ff;
   assign rsp_action     = act_ff;
   assign rsp_tx_byte    = tx_ff;
   assign rsp_flash_addr = addr_ff;
   assign rsp_flash_word = word_ff;
   assign rsp_last       = last_ff;

endmodule

/* src/serial_bootloader_command_parser.sv */
`timescale 1ns / 1ps
// The first result of a byte passes through the job queue slot and the result output register.
// Throughput: one byte per cycle while the two-entry job queue has room; the result
// sequencer emits one result per cycle while results are popped, and a job causes 1 to 3
// results, or 24 + NAME_BYTES for info.
// Reset is synchronous and active high: parser, queue and output go empty, registers to defaults.
module serial_bootloader_command_parser import sbcp_pkg::*; #(
   parameter int NAME_BYTES = NAME_BYTES_DEF
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_push,
   output logic                 req_full,
   input  logic [7:0]           req_rx_byte,
   output logic                 rsp_empty,
   input  logic                 rsp_pop,
   output logic [2:0]           rsp_action,
   output logic [7:0]           rsp_tx_byte,
   output logic [15:0]          rsp_flash_addr,
   output logic [15:0]          rsp_flash_word,
   output logic                 rsp_last,
   input  logic                 csr_valid,
   output logic                 csr_ready,
   input  logic [CSR_IDX_W-1:0] csr_index,
   input  logic [15:0]          csr_data
);

   logic    byte_take;
   logic    job_push;
   job_type job_new;
   logic    head_valid;
   job_type head_job;
   logic    job_pop;

   assign csr_ready = 1'b1;
   assign byte_take = req_push && !req_full;

   sbcp_front u_front (
      .clock      (clock),
      .reset      (reset),
      .byte_valid (byte_take),
      .rx_byte    (req_rx_byte),
      .job_push   (job_push),
      .job        (job_new)
   );

   sbcp_jobq u_jobq (
      .clock      (clock),
      .reset      (reset),
      .push       (job_push),
      .push_job   (job_new),
      .full       (req_full),
      .pop        (job_pop),
      .head_valid (head_valid),
      .head_job   (head_job)
   );

   sbcp_back #(
      .NAME_BYTES (NAME_BYTES)
   ) u_back (
      .clock          (clock),
      .reset          (reset),
      .csr_we         (csr_valid && csr_ready),
      .csr_index      (csr_index),
      .csr_data       (csr_data),
      .job_valid      (head_valid),
      .job            (head_job),
      .job_pop        (job_pop),
      .rsp_pop        (rsp_pop),
      .rsp_empty      (rsp_empty),
      .rsp_action     (rsp_action),
      .rsp_tx_byte    (rsp_tx_byte),
      .rsp_flash_addr (rsp_flash_addr),
      .rsp_flash_word (rsp_flash_word),
      .rsp_last       (rsp_last)
   );

endmodule

/* sim/tb.sv */
`timescale 1ns / 1ps

module tb;
   import sbcp_pkg::*;

   localparam int NAMELEN = NAME_BYTES_DEF;
   localparam int CYCLE_LIMIT = 2000000;
   localparam int SETTLE = 12;
   localparam int MAX_PRINTS = 30;
   localparam logic [CSR_IDX_W-1:0] CSR_STRAY = {CSR_IDX_W{1'b1}};

   localparam logic [2:0] P_HUNT  = 3'd0;
   localparam logic [2:0] P_CMD   = 3'd1;
   localparam logic [2:0] P_ADDR  = 3'd2;
   localparam logic [2:0] P_COUNT = 3'd3;
   localparam logic [2:0] P_DATA  = 3'd4;

   typedef struct packed {
      logic [2:0]  action;
      logic [7:0]  tx_byte;
      logic [15:0] flash_addr;
      logic [15:0] flash_word;
      logic        last;
   } reply_type;

   logic                 clock;
   logic                 reset = 1'b1;
   logic                 req_push = 1'b0;
   logic                 req_full;
   logic [7:0]           req_rx_byte = 8'h00;
   logic                 rsp_empty;
   logic                 rsp_pop = 1'b0;
   logic [2:0]           rsp_action;
   logic [7:0]           rsp_tx_byte;
   logic [15:0]          rsp_flash_addr;
   logic [15:0]          rsp_flash_word;
   logic                 rsp_last;
   logic                 csr_valid = 1'b0;
   logic                 csr_ready;
   logic [CSR_IDX_W-1:0] csr_index = '0;
   logic [15:0]          csr_data = 16'h0000;

   serial_bootloader_command_parser dut (
      .clock(clock), .reset(reset),
      .req_push(req_push), .req_full(req_full), .req_rx_byte(req_rx_byte),
      .rsp_empty(rsp_empty), .rsp_pop(rsp_pop), .rsp_action(rsp_action),
      .rsp_tx_byte(rsp_tx_byte), .rsp_flash_addr(rsp_flash_addr),
      .rsp_flash_word(rsp_flash_word), .rsp_last(rsp_last),
      .csr_valid(csr_valid), .csr_ready(csr_ready), .csr_index(csr_index),
      .csr_data(csr_data)
   );

   // Predicted parser state, starting from its reset values.
   logic [15:0]  flash_words = FLASH_SIZE_RST;
   logic [15:0]  row_size = ROW_SIZE_RST;
   logic [15:0]  loader_start = LOADER_RST;
   logic [2:0]   ph = P_HUNT;
   logic [7:0]   cmd_byte = 8'h00;
   logic [2:0]   field_cnt = 3'd0;
   logic [15:0]  cur_addr = 16'h0000;
   logic [15:0]  words_left = 16'h0000;
   logic [7:0]   low_hold = 8'h00;
   logic [15:0]  first_wd = 16'h0000;
   logic         first_flag = 1'b1;

   logic [7:0] dev_name [0:8] = '{8'h42, 8'h75, 8'h63, 8'h6B, 8'h43, 8'h6C, 8'h69,
                                  8'h63, 8'h6B};

   logic [7:0]  rx_stream [$];
   reply_type   replies_due [$];
   reply_type   byte_replies [$];
   int          errors = 0;
   bit          calm = 1'b0;
   int          in_gap = 0;
   int          out_gap = 0;
   int unsigned cycles = 0;

   initial begin
      clock = 1'b0;
      forever #6 clock = ~clock;
   end

   task automatic report_mismatch(input string what, input logic [15:0] got,
                                  input logic [15:0] want);
      if (errors < MAX_PRINTS)
         $display("mismatch in %s: got %0h, expected %0h at %0t", what, got, want, $realtime);
      errors++;
   endtask

   function automatic void emit(input logic [2:0] act, input logic [7:0] tx,
                                input logic [15:0] addr, input logic [15:0] wd);
      reply_type r;
      r.action = act;
      r.tx_byte = tx;
      r.flash_addr = addr;
      r.flash_word = wd;
      r.last = 1'b0;
      byte_replies.push_back(r);
   endfunction

   function automatic void emit_byte(input logic [7:0] tx);
      emit(ACT_SEND, tx, 16'h0000, 16'h0000);
   endfunction

   function automatic void emit_word(input logic [15:0] w);
      emit_byte(w[7:0]);
      emit_byte(w[15:8]);
   endfunction

   function automatic void emit_ack(input logic [7:0] c);
      emit_byte(CH_START);
      emit_byte(c);
   endfunction

   // Advances the predicted parser by one received byte and queues what it causes.
   function automatic void parse_byte(input logic [7:0] b);
      logic [15:0] w;
      int i;
      byte_replies.delete();
      unique case (ph)
         P_CMD: begin
            cmd_byte = b;
            ph = P_HUNT;
            if (b == CH_SYNC || b == CH_BOOT) begin
               emit_ack(b);
            end else if (b == CH_INFO) begin
               emit_byte(8'(23 + NAMELEN));
               emit_byte(8'd1); emit_word(16'd1);
               emit_byte(8'd8); emit_word(flash_words); emit_word(16'd0);
               emit_byte(8'd3); emit_word(row_size);
               emit_byte(8'd4); emit_word(row_size);
               emit_byte(8'd5); emit_word(INFO_VERSION);
               emit_byte(8'd6); emit_word(loader_start); emit_word(16'd0);
               emit_byte(8'd7);
               for (i = 0; i < NAMELEN && i < 32; i++)
                  emit_byte(i < 9 ? dev_name[i] : 8'h00);
            end else if (b == CH_RUN) begin
               emit(ACT_RUN, 8'h00, 16'h0000, 16'h0000);
            end else if (b == CH_ERASE || b == CH_WRITE) begin
               ph = P_ADDR;
               field_cnt = 3'd0;
            end else begin
               emit(ACT_RESTART, 8'h00, 16'h0000, 16'h0000);
            end
         end
         P_ADDR: begin
            // Address low then high; the two bytes after it are skipped.
            if (field_cnt == 3'd0) cur_addr = {8'h00, b};
            else if (field_cnt == 3'd1) cur_addr[15:8] = b;
            field_cnt = field_cnt + 3'd1;
            if (field_cnt >= 3'd4) begin
               field_cnt = 3'd0;
               if (cmd_byte == CH_ERASE) begin
                  emit(ACT_ERASE, 8'h00, cur_addr, 16'h0000);
                  emit_ack(CH_ERASE);
                  ph = P_HUNT;
               end else begin
                  ph = P_COUNT;
               end
            end
         end
         P_COUNT: begin
            if (field_cnt == 3'd0) begin
               low_hold = b;
               field_cnt = 3'd1;
            end else begin
               field_cnt = 3'd0;
               words_left = {b, low_hold};
               if (words_left == 16'd0) begin
                  // An empty write commits the first word of the last write that had any.
                  emit(ACT_COMMIT, 8'h00, cur_addr, first_wd);
                  emit_ack(CH_WRITE);
                  ph = P_HUNT;
               end else begin
                  first_flag = 1'b1;
                  ph = P_DATA;
               end
            end
         end
         P_DATA: begin
            if (field_cnt == 3'd0) begin
               low_hold = b;
               field_cnt = 3'd1;
            end else begin
               w = {b, low_hold};
               field_cnt = 3'd0;
               if (first_flag) begin
                  first_wd = w;
                  first_flag = 1'b0;
               end
               if (words_left > 16'd1) begin
                  emit(ACT_LATCH, 8'h00, cur_addr, w);
                  cur_addr = cur_addr + 16'd1;
                  words_left = words_left - 16'd1;
               end else begin
                  emit(ACT_COMMIT, 8'h00, cur_addr, w);
                  words_left = 16'd0;
                  emit_ack(CH_WRITE);
                  ph = P_HUNT;
               end
            end
         end
         default: ph = (b == CH_START) ? P_CMD : P_HUNT;
      endcase
      if (byte_replies.size() > 0) begin
         byte_replies[byte_replies.size() - 1].last = 1'b1;
         foreach (byte_replies[k]) replies_due.push_back(byte_replies[k]);
      end
   endfunction

   // Input side: one byte per accepted push, with random bursts of idle cycles.
   always @(posedge clock) begin : drive_rx
      logic       nxt_push;
      logic [7:0] nxt_byte;
      if (reset) begin
         req_push <= 1'b0;
         req_rx_byte <= 8'h00;
         in_gap = 0;
      end else begin
         nxt_push = req_push;
         nxt_byte = req_rx_byte;
         if (req_push && !req_full) begin
            parse_byte(req_rx_byte);
            nxt_push = 1'b0;
         end
         if (!nxt_push) begin
            if (in_gap > 0) begin
               in_gap--;
            end else if (rx_stream.size() > 0) begin
               if (!calm && $urandom_range(0, 9) == 0) begin
                  in_gap = $urandom_range(0, 8);
               end else begin
                  nxt_push = 1'b1;
                  nxt_byte = rx_stream.pop_front();
               end
            end
         end
         req_push <= nxt_push;
         req_rx_byte <= nxt_byte;
      end
   end

   // Result side: check each popped result against the oldest prediction.
   always @(posedge clock) begin : watch_rsp
      reply_type got;
      reply_type want;
      logic      nxt_pop;
      if (reset) begin
         rsp_pop <= 1'b0;
         out_gap = 0;
      end else begin
         if (rsp_pop && !rsp_empty) begin
            got.action = rsp_action;
            got.tx_byte = rsp_tx_byte;
            got.flash_addr = rsp_flash_addr;
            got.flash_word = rsp_flash_word;
            got.last = rsp_last;
            if (replies_due.size() == 0) begin
               report_mismatch("unexpected result, action", 16'(got.action), 16'h0000);
            end else begin
               want = replies_due.pop_front();
               if (got.action !== want.action)
                  report_mismatch("action", 16'(got.action), 16'(want.action));
               if (got.tx_byte !== want.tx_byte)
                  report_mismatch("tx_byte", 16'(got.tx_byte), 16'(want.tx_byte));
               if (got.flash_addr !== want.flash_addr)
                  report_mismatch("flash_addr", got.flash_addr, want.flash_addr);
               if (got.flash_word !== want.flash_word)
                  report_mismatch("flash_word", got.flash_word, want.flash_word);
               if (got.last !== want.last)
                  report_mismatch("last", 16'(got.last), 16'(want.last));
            end
         end
         if (out_gap > 0) begin
            out_gap--;
            nxt_pop = 1'b0;
         end else if (!calm && $urandom_range(0, 9) == 0) begin
            out_gap = $urandom_range(0, 8);
            nxt_pop = 1'b0;
         end else begin
            nxt_pop = 1'b1;
         end
         rsp_pop <= nxt_pop;
      end
   end

   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles == CYCLE_LIMIT) begin
         $display("== FAIL ==");
         $finish;
      end
   end

   // Writes every register, then one index past the last, which must be ignored.
   task automatic configure(input logic [15:0] fsize, input logic [15:0] rsize,
                            input logic [15:0] lstart);
      logic [CSR_IDX_W-1:0] idx [4];
      logic [15:0]          val [4];
      idx = '{CSR_FLASH_SIZE, CSR_ROW_SIZE, CSR_LOADER, CSR_STRAY};
      val = '{fsize, rsize, lstart, 16'($urandom)};
      for (int k = 0; k < 4; k++) begin
         csr_valid <= 1'b1;
         csr_index <= idx[k];
         csr_data <= val[k];
         do @(posedge clock); while (!csr_ready);
         unique case (idx[k])
            CSR_FLASH_SIZE: flash_words = val[k];
            CSR_ROW_SIZE:   row_size = val[k];
            CSR_LOADER:     loader_start = val[k];
            default: ;
         endcase
      end
      csr_valid <= 1'b0;
   endtask

   task automatic drain;
      while (rx_stream.size() != 0 || req_push || replies_due.size() != 0)
         @(posedge clock);
      repeat (SETTLE) @(posedge clock);
   endtask

   task automatic push_rand(input int n);
      for (int k = 0; k < n; k++) rx_stream.push_back(8'($urandom));
   endtask

   // Mostly well-formed commands with random content, plus noise and cut-off commands.
   task automatic add_traffic(input int target);
      int added;
      int pick;
      int cnt;
      int give;
      added = 0;
      while (added < target) begin
         pick = $urandom_range(0, 99);
         if (pick < 10) begin
            rx_stream.push_back(CH_START);
            rx_stream.push_back($urandom_range(0, 1) ? CH_SYNC : CH_BOOT);
            added += 2;
         end else if (pick < 20) begin
            rx_stream.push_back(CH_START);
            rx_stream.push_back(CH_INFO);
            added += 2;
         end else if (pick < 26) begin
            rx_stream.push_back(CH_START);
            rx_stream.push_back(CH_RUN);
            added += 2;
         end else if (pick < 32) begin
            rx_stream.push_back(CH_START);
            push_rand(1);
            added += 2;
         end else if (pick < 48) begin
            rx_stream.push_back(CH_START);
            rx_stream.push_back(CH_ERASE);
            push_rand(4);
            added += 6;
         end else if (pick < 82) begin
            cnt = ($urandom_range(0, 7) == 0) ? 0 : $urandom_range(1, 5);
            rx_stream.push_back(CH_START);
            rx_stream.push_back(CH_WRITE);
            push_rand(4);
            rx_stream.push_back(8'(cnt));
            rx_stream.push_back(8'h00);
            push_rand(2 * cnt);
            added += 8 + 2 * cnt;
         end else if (pick < 92) begin
            give = $urandom_range(1, 4);
            push_rand(give);
            added += give;
         end else if ($urandom_range(0, 1) == 0) begin
            give = $urandom_range(0, 3);
            rx_stream.push_back(CH_START);
            rx_stream.push_back(CH_ERASE);
            push_rand(give);
            added += 2 + give;
         end else begin
            // The missing words are taken from whatever bytes follow.
            cnt = $urandom_range(2, 5);
            give = $urandom_range(0, cnt - 1);
            rx_stream.push_back(CH_START);
            rx_stream.push_back(CH_WRITE);
            push_rand(4);
            rx_stream.push_back(8'(cnt));
            rx_stream.push_back(8'h00);
            push_rand(2 * give);
            added += 8 + 2 * give;
         end
      end
   endtask

   initial begin
      logic [7:0] opening [$];
      opening = '{8'hFF, CH_START, CH_SYNC, CH_START, CH_BOOT, CH_START, CH_INFO,
                  CH_START, CH_RUN, CH_START, CH_START,
                  CH_START, CH_ERASE, 8'hFF, 8'hFF, 8'h00, 8'h00,
                  CH_START, CH_WRITE, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00};
      repeat (5) @(posedge clock);
      reset <= 1'b0;
      rx_stream = opening;
      add_traffic(100);
      drain();
      configure(16'h0000, 16'h0001, 16'h0000);
      add_traffic(100);
      drain();
      configure(16'hFFFF, 16'hFFFF, 16'hFFFF);
      add_traffic(100);
      drain();
      configure(16'($urandom), 16'($urandom_range(1, 65535)), 16'($urandom));
      calm = 1'b1;
      add_traffic(100);
      drain();
      if (errors == 0) $display("== PASS ==");
      else $display("== FAIL ==");
      $finish;
   end

endmodule
